// ===== hw/rtl/etrf_pkg.sv =====
`default_nettype none
package etrf_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// register index codes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAT_X = 3'd0,
		REG_SAT_Y = 3'd1,
		REG_SAT_Z = 3'd2,
		REG_SUN_X = 3'd3,
		REG_SUN_Y = 3'd4,
		REG_SUN_Z = 3'd5,
		REG_EARTH_R = 3'd6
	} reg_idx_t;

	localparam logic [31:0] EARTH_R_RESET = 32'd26124849;
	// pi in Q2.30, truncated
	localparam logic [31:0] PI30 = 32'd3373259426;
	localparam logic [31:0] FLUX_MAX = 32'h7fff_ffff;

	// direction flags that ride along with each beat
	typedef struct packed {
		logic last;
		logic vis;
		logic lit;
		logic dz;
		logic [2:0] dneg;
	} flag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/etrf_dly.sv =====
`default_nettype none
module etrf_dly #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  wire logic         clk,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] sh_q [N];

	always_ff @(posedge clk) begin
		sh_q[0] <= d;
		for (int i = 1; i < N; i++) begin
			sh_q[i] <= sh_q[i-1];
		end
	end

	assign q = sh_q[N-1];

endmodule
`default_nettype wire

// ===== hw/rtl/etrf_mul.sv =====
`default_nettype none
// Pipelined unsigned multiplier: one CW-bit slice of b per stage.
module etrf_mul #(
	parameter int AW = 64,
	parameter int BW = 64,
	parameter int CW = 16
) (
	input  wire logic             clk,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic      [AW+BW-1:0] p
);

	localparam int NS = (BW + CW - 1) / CW;
	localparam int PW = AW + BW;
	localparam int BPW = NS * CW;

	logic [AW-1:0]  a_s   [NS];
	logic [BPW-1:0] b_s   [NS];
	logic [PW-1:0]  acc_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [AW-1:0]    a_in;
		logic [BPW-1:0]   b_in;
		logic [PW-1:0]    acc_in;
		logic [AW+CW-1:0] pp;

		if (k == 0) begin : g_first
			assign a_in = a;
			assign b_in = BPW'(b);
			assign acc_in = '0;
		end else begin : g_next
			assign a_in = a_s[k-1];
			assign b_in = b_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		assign pp = (AW+CW)'(a_in) * (AW+CW)'(b_in[k*CW +: CW]);

		always_ff @(posedge clk) begin
			a_s[k] <= a_in;
			b_s[k] <= b_in;
			acc_s[k] <= acc_in + (PW'(pp) << (k * CW));
		end
	end

	assign p = acc_s[NS-1];

endmodule
`default_nettype wire

// ===== hw/rtl/etrf_div.sv =====
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// Needs x >> QW below d; the quotient then fits QW bits.
module etrf_div #(
	parameter int DW = 66,
	parameter int QW = 61
) (
	input  wire logic             clk,
	input  wire logic [DW+QW-1:0] x,
	input  wire logic [DW-1:0]    d,
	output logic      [QW-1:0]    q
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] lo_s  [QW];
	logic [DW-1:0] d_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [QW-1:0] lo_in;
		logic [DW-1:0] d_in;
		logic [DW:0]   t;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = x[DW+QW-1:QW];
			assign lo_in = x[QW-1:0];
			assign d_in = d;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign lo_in = lo_s[k-1];
			assign d_in = d_s[k-1];
		end

		assign t = {rem_in, lo_in[QW-1]};
		assign ge = (t >= {1'b0, d_in});
		assign diff = t - {1'b0, d_in};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
			lo_s[k] <= {lo_in[QW-2:0], ge};
			d_s[k] <= d_in;
		end
	end

	assign q = lo_s[QW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/etrf_sqrt.sv =====
`default_nettype none
// Pipelined integer square root, one root bit per stage: r = floor(sqrt(x)).
module etrf_sqrt #(
	parameter int RW = 33
) (
	input  wire logic            clk,
	input  wire logic [2*RW-1:0] x,
	output logic      [RW-1:0]   r
);

	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] xs_s   [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+1:0]   rem_in;
		logic [RW-1:0]   root_in;
		logic [2*RW-1:0] xs_in;
		logic [RW+3:0]   t;
		logic [RW+3:0]   trial;
		logic [RW+3:0]   nt;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign xs_in = x;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign xs_in = xs_s[k-1];
		end

		assign t = {rem_in, xs_in[2*RW-1 -: 2]};
		assign trial = (RW+4)'({root_in, 2'b01});
		assign ge = (t >= trial);
		assign nt = t - trial;

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? nt[RW+1:0] : t[RW+1:0];
			root_s[k] <= {root_in[RW-2:0], ge};
			xs_s[k] <= {xs_in[2*RW-3:0], 2'b00};
		end
	end

	assign r = root_s[RW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/earth_triangle_radiation_flux.sv =====
`default_nettype none
// Earth triangle radiation flux.
// Configuration: write satellite position, Sun point and Earth radius through
// cfg_we / cfg_index / cfg_data, one register per clock, while no triangle is
// in flight. Indexes beyond the earth radius register are dropped.
// Input channel: a triangle beat is taken at each rising edge with start high
// and busy low. busy stays low: a new triangle may enter on every clock.
// Output channel: done is high for exactly one cycle with the result on the
// output ports; the receiver takes it at the end of that cycle and cannot
// stall, so nothing backs up into the pipeline.
// Results: one per triangle, in order, from accept to done.
// Throughput: one triangle per cycle. The latency is set by the direction
// path: a 61-stage restoring divider followed by a 31-stage square root.
// The flux path (d squared, d cubed, a 31-stage divider) runs in parallel.
// Reset clears the valid line and done and loads the register reset values;
// triangles in flight at reset are dropped.
module earth_triangle_radiation_flux (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic signed [31:0]               centroid_x,
	input  wire logic signed [31:0]               centroid_y,
	input  wire logic signed [31:0]               centroid_z,
	input  wire logic        [23:0]               tri_area,
	input  wire logic        [15:0]               longwave_radiance,
	input  wire logic        [15:0]               shortwave_radiance,
	input  wire logic                             last_triangle,
	input  wire logic                             cfg_we,
	input  wire logic [etrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [etrf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                  done,
	output logic                                  visible,
	output logic                                  sunlit,
	output logic signed [31:0]                    dir_x,
	output logic signed [31:0]                    dir_y,
	output logic signed [31:0]                    dir_z,
	output logic signed [31:0]                    flux_longwave,
	output logic signed [31:0]                    flux_shortwave,
	output logic                                  end_of_table
);

	// Timeline, in cycles after accept, of when each value sits in a register.
	localparam int T_D2 = 3;                  // d squared and flags
	localparam int T_N = T_D2 + 1;            // numerator term N
	localparam int MUL_NUM_LAT = 3;           // 40-bit factor, 16-bit slices
	localparam int MUL_D1_LAT = 4;            // 64-bit factor, 16-bit slices
	localparam int MUL_D2_LAT = 5;            // 33-bit factor, 8-bit slices
	localparam int SQD_LAT = 33;
	localparam int T_NUM = T_N + MUL_NUM_LAT;
	localparam int T_D1 = T_D2 + MUL_D1_LAT;
	localparam int T_S = T_D2 + SQD_LAT;
	localparam int T_DEN = T_S + MUL_D2_LAT;
	localparam int FDIV_QW = 31;
	localparam int T_FQ = T_DEN + FDIV_QW;
	localparam int DDIV_QW = 61;
	localparam int DSQ_RW = 31;
	localparam int T_DIR = T_D2 + DDIV_QW + DSQ_RW;
	localparam int VLD_LEN = T_DIR;

	localparam int NUM_W = 107;
	localparam int D1_W = 130;
	localparam int DEN_W = 163;

	// ---------------- configuration registers ----------------
	logic signed [31:0] sat_x_q, sat_y_q, sat_z_q;
	logic signed [31:0] sun_x_q, sun_y_q, sun_z_q;
	logic [31:0]        earth_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_x_q <= '0;
			sat_y_q <= '0;
			sat_z_q <= '0;
			sun_x_q <= '0;
			sun_y_q <= '0;
			sun_z_q <= '0;
			earth_r_q <= etrf_pkg::EARTH_R_RESET;
		end else if (cfg_we) begin
			case (etrf_pkg::reg_idx_t'(cfg_index))
				etrf_pkg::REG_SAT_X:   sat_x_q <= $signed(cfg_data);
				etrf_pkg::REG_SAT_Y:   sat_y_q <= $signed(cfg_data);
				etrf_pkg::REG_SAT_Z:   sat_z_q <= $signed(cfg_data);
				etrf_pkg::REG_SUN_X:   sun_x_q <= $signed(cfg_data);
				etrf_pkg::REG_SUN_Y:   sun_y_q <= $signed(cfg_data);
				etrf_pkg::REG_SUN_Z:   sun_z_q <= $signed(cfg_data);
				etrf_pkg::REG_EARTH_R: earth_r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Terms that depend on configuration alone, registered behind the configuration
	// registers (s2_q behind the squared terms); they settle before a triangle needs them.
	logic [63:0]        r2_q, pir_q, s2_q;
	logic signed [63:0] sqsat_x_q, sqsat_y_q, sqsat_z_q;

	always_ff @(posedge clk) begin
		r2_q <= 64'(earth_r_q) * 64'(earth_r_q);
		pir_q <= 64'(etrf_pkg::PI30) * 64'(earth_r_q);
		sqsat_x_q <= sat_x_q * sat_x_q;
		sqsat_y_q <= sat_y_q * sat_y_q;
		sqsat_z_q <= sat_z_q * sat_z_q;
		s2_q <= $unsigned(sqsat_x_q) + $unsigned(sqsat_y_q) + $unsigned(sqsat_z_q);
	end

	// ---------------- handshake and valid line ----------------
	logic                accept;
	logic [VLD_LEN-1:0]  vld_q;
	logic                done_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q <= {vld_q[VLD_LEN-2:0], accept};
			done_q <= vld_q[VLD_LEN-1];
		end
	end

	// ---------------- stage 1: dot products and differences ----------------
	logic signed [63:0] ps_x_s1, ps_y_s1, ps_z_s1;
	logic signed [63:0] pu_x_s1, pu_y_s1, pu_z_s1;
	logic signed [32:0] d_x_s1, d_y_s1, d_z_s1;
	logic [39:0]        ra_lw_s1, ra_sw_s1;
	logic               last_s1;

	always_ff @(posedge clk) begin
		ps_x_s1 <= sat_x_q * centroid_x;
		ps_y_s1 <= sat_y_q * centroid_y;
		ps_z_s1 <= sat_z_q * centroid_z;
		pu_x_s1 <= sun_x_q * centroid_x;
		pu_y_s1 <= sun_y_q * centroid_y;
		pu_z_s1 <= sun_z_q * centroid_z;
		d_x_s1 <= 33'(sat_x_q) - 33'(centroid_x);
		d_y_s1 <= 33'(sat_y_q) - 33'(centroid_y);
		d_z_s1 <= 33'(sat_z_q) - 33'(centroid_z);
		ra_lw_s1 <= 40'(longwave_radiance) * 40'(tri_area);
		ra_sw_s1 <= 40'(shortwave_radiance) * 40'(tri_area);
		last_s1 <= last_triangle;
	end

	// ---------------- stage 2: visibility tests, squared components -------
	logic signed [66:0] dot_sat, dot_sun, r2_ext;
	logic [32:0]        dmag_x, dmag_y, dmag_z;
	logic               vis_s2, lit_s2, last_s2;
	logic [2:0]         dneg_s2;
	logic [64:0]        dsq_x_s2, dsq_y_s2, dsq_z_s2;
	logic [39:0]        ra_lw_s2, ra_sw_s2;

	always_comb begin
		dot_sat = 67'(ps_x_s1) + 67'(ps_y_s1) + 67'(ps_z_s1);
		dot_sun = 67'(pu_x_s1) + 67'(pu_y_s1) + 67'(pu_z_s1);
		r2_ext = $signed({3'b000, r2_q});
		dmag_x = d_x_s1[32] ? $unsigned(-d_x_s1) : $unsigned(d_x_s1);
		dmag_y = d_y_s1[32] ? $unsigned(-d_y_s1) : $unsigned(d_y_s1);
		dmag_z = d_z_s1[32] ? $unsigned(-d_z_s1) : $unsigned(d_z_s1);
	end

	always_ff @(posedge clk) begin
		vis_s2 <= (dot_sat > r2_ext);
		lit_s2 <= (dot_sun > r2_ext);
		last_s2 <= last_s1;
		dneg_s2 <= {d_z_s1[32], d_y_s1[32], d_x_s1[32]};
		dsq_x_s2 <= 65'(dmag_x) * 65'(dmag_x);
		dsq_y_s2 <= 65'(dmag_y) * 65'(dmag_y);
		dsq_z_s2 <= 65'(dmag_z) * 65'(dmag_z);
		ra_lw_s2 <= ra_lw_s1;
		ra_sw_s2 <= ra_sw_s1;
	end

	// ---------------- stage 3: squared distance ----------------
	logic [65:0] d2_s3;
	logic [64:0] dsq_x_s3, dsq_y_s3, dsq_z_s3;
	logic        vis_s3, lit_s3, last_s3;
	logic [2:0]  dneg_s3;
	logic [39:0] ra_lw_s3, ra_sw_s3;

	always_ff @(posedge clk) begin
		d2_s3 <= 66'(dsq_x_s2) + 66'(dsq_y_s2) + 66'(dsq_z_s2);
		dsq_x_s3 <= dsq_x_s2;
		dsq_y_s3 <= dsq_y_s2;
		dsq_z_s3 <= dsq_z_s2;
		vis_s3 <= vis_s2;
		lit_s3 <= lit_s2;
		last_s3 <= last_s2;
		dneg_s3 <= dneg_s2;
		ra_lw_s3 <= ra_lw_s2;
		ra_sw_s3 <= ra_sw_s2;
	end

	// ---------------- stage 4: N = |S|^2 - d^2 - R^2 ----------------
	logic signed [67:0] nval;
	logic [66:0]        nmag_s4;
	logic               nneg_s4;
	logic [39:0]        ra_lw_s4, ra_sw_s4;

	assign nval = $signed({2'b00, s2_q}) - $signed({2'b00, d2_s3}) - $signed({4'b0000, r2_q});

	always_ff @(posedge clk) begin
		nneg_s4 <= nval[67];
		nmag_s4 <= nval[67] ? 67'($unsigned(-nval)) : 67'($unsigned(nval));
		ra_lw_s4 <= ra_lw_s3;
		ra_sw_s4 <= ra_sw_s3;
	end

	// ---------------- flags toward the output ----------------
	etrf_pkg::flag_t flag_in, flag_out;

	always_comb begin
		flag_in.last = last_s3;
		flag_in.vis = vis_s3;
		flag_in.lit = lit_s3;
		flag_in.dz = (d2_s3 == '0);
		flag_in.dneg = dneg_s3;
	end

	etrf_dly #(.W($bits(etrf_pkg::flag_t)), .N(T_DIR - T_D2)) u_flag_dly (
		.clk(clk), .d(flag_in), .q(flag_out)
	);

	// ---------------- direction: sqrt(d_i^2 * 2^60 / d^2) ----------------
	logic [DDIV_QW-1:0] dq_x, dq_y, dq_z;
	logic [DSQ_RW-1:0]  dm_x, dm_y, dm_z;

	etrf_div #(.DW(66), .QW(DDIV_QW)) u_div_dx (
		.clk(clk), .x((66+DDIV_QW)'({dsq_x_s3, 60'b0})), .d(d2_s3), .q(dq_x)
	);
	etrf_div #(.DW(66), .QW(DDIV_QW)) u_div_dy (
		.clk(clk), .x((66+DDIV_QW)'({dsq_y_s3, 60'b0})), .d(d2_s3), .q(dq_y)
	);
	etrf_div #(.DW(66), .QW(DDIV_QW)) u_div_dz (
		.clk(clk), .x((66+DDIV_QW)'({dsq_z_s3, 60'b0})), .d(d2_s3), .q(dq_z)
	);

	etrf_sqrt #(.RW(DSQ_RW)) u_sqrt_dx (.clk(clk), .x((2*DSQ_RW)'(dq_x)), .r(dm_x));
	etrf_sqrt #(.RW(DSQ_RW)) u_sqrt_dy (.clk(clk), .x((2*DSQ_RW)'(dq_y)), .r(dm_y));
	etrf_sqrt #(.RW(DSQ_RW)) u_sqrt_dz (.clk(clk), .x((2*DSQ_RW)'(dq_z)), .r(dm_z));

	// ---------------- flux denominator: PI30 * R * d^2 * floor(d) --------
	logic [32:0]      dist_rt;
	logic [D1_W-1:0]  den1, den1_dly;
	logic [DEN_W-1:0] den;

	etrf_sqrt #(.RW(SQD_LAT)) u_sqrt_d (.clk(clk), .x(d2_s3), .r(dist_rt));

	etrf_mul #(.AW(66), .BW(64), .CW(16)) u_mul_d1 (
		.clk(clk), .a(d2_s3), .b(pir_q), .p(den1)
	);

	etrf_dly #(.W(D1_W), .N(T_S - T_D1)) u_d1_dly (
		.clk(clk), .d(den1), .q(den1_dly)
	);

	etrf_mul #(.AW(D1_W), .BW(33), .CW(8)) u_mul_den (
		.clk(clk), .a(den1_dly), .b(dist_rt), .p(den)
	);

	// ---------------- flux numerators: radiance * area * |N| -------------
	logic [NUM_W-1:0]   num_lw, num_sw, num_lw_d, num_sw_d;

	etrf_mul #(.AW(67), .BW(40), .CW(16)) u_mul_nlw (
		.clk(clk), .a(nmag_s4), .b(ra_lw_s4), .p(num_lw)
	);
	etrf_mul #(.AW(67), .BW(40), .CW(16)) u_mul_nsw (
		.clk(clk), .a(nmag_s4), .b(ra_sw_s4), .p(num_sw)
	);

	etrf_dly #(.W(2*NUM_W), .N(T_DEN - T_NUM)) u_num_dly (
		.clk(clk), .d({num_lw, num_sw}), .q({num_lw_d, num_sw_d})
	);

	// Saturate where the quotient would reach 2^31; a zero divisor lands
	// there too. A zero numerator gives zero flux whatever the divisor.
	logic [3:0]         fclass_in, fclass;
	logic               nneg_d;
	logic [FDIV_QW-1:0] fq_lw, fq_sw;

	assign fclass_in = {
		(DEN_W'({num_lw_d, 40'b0}) >= den), (num_lw_d == '0),
		(DEN_W'({num_sw_d, 40'b0}) >= den), (num_sw_d == '0)
	};

	etrf_dly #(.W(4), .N(FDIV_QW)) u_fclass_dly (
		.clk(clk), .d(fclass_in), .q(fclass)
	);
	etrf_dly #(.W(1), .N(T_FQ - T_N)) u_nneg_dly (
		.clk(clk), .d(nneg_s4), .q(nneg_d)
	);

	etrf_div #(.DW(DEN_W), .QW(FDIV_QW)) u_div_flw (
		.clk(clk), .x((DEN_W+FDIV_QW)'({num_lw_d, 71'b0})), .d(den), .q(fq_lw)
	);
	etrf_div #(.DW(DEN_W), .QW(FDIV_QW)) u_div_fsw (
		.clk(clk), .x((DEN_W+FDIV_QW)'({num_sw_d, 71'b0})), .d(den), .q(fq_sw)
	);

	logic [31:0] fmag_lw, fmag_sw, fval_lw, fval_sw, flw_d, fsw_d;

	always_comb begin
		fmag_lw = fclass[2] ? 32'd0 : (fclass[3] ? etrf_pkg::FLUX_MAX : {1'b0, fq_lw});
		fmag_sw = fclass[0] ? 32'd0 : (fclass[1] ? etrf_pkg::FLUX_MAX : {1'b0, fq_sw});
		fval_lw = nneg_d ? (32'd0 - fmag_lw) : fmag_lw;
		fval_sw = nneg_d ? (32'd0 - fmag_sw) : fmag_sw;
	end

	etrf_dly #(.W(64), .N(T_DIR - T_FQ)) u_flux_dly (
		.clk(clk), .d({fval_lw, fval_sw}), .q({flw_d, fsw_d})
	);

	// ---------------- output register ----------------
	logic        dir_ok;
	logic [31:0] dx_mag, dy_mag, dz_mag;
	logic        visible_q, sunlit_q, eot_q;
	logic [31:0] dir_x_q, dir_y_q, dir_z_q, flw_q, fsw_q;

	assign dir_ok = flag_out.vis && !flag_out.dz;
	assign dx_mag = 32'(dm_x);
	assign dy_mag = 32'(dm_y);
	assign dz_mag = 32'(dm_z);

	always_ff @(posedge clk) begin
		visible_q <= flag_out.vis;
		sunlit_q <= flag_out.vis && flag_out.lit;
		eot_q <= flag_out.last;
		dir_x_q <= !dir_ok ? 32'd0 : (flag_out.dneg[0] ? 32'd0 - dx_mag : dx_mag);
		dir_y_q <= !dir_ok ? 32'd0 : (flag_out.dneg[1] ? 32'd0 - dy_mag : dy_mag);
		dir_z_q <= !dir_ok ? 32'd0 : (flag_out.dneg[2] ? 32'd0 - dz_mag : dz_mag);
		flw_q <= flag_out.vis ? flw_d : 32'd0;
		fsw_q <= (flag_out.vis && flag_out.lit) ? fsw_d : 32'd0;
	end

	assign done = done_q;
	assign visible = visible_q;
	assign sunlit = sunlit_q;
	assign end_of_table = eot_q;
	assign dir_x = $signed(dir_x_q);
	assign dir_y = $signed(dir_y_q);
	assign dir_z = $signed(dir_z_q);
	assign flux_longwave = $signed(flw_q);
	assign flux_shortwave = $signed(fsw_q);

	// ---------------- assertions ----------------
	// a result beat appears only for a triangle taken the full latency earlier
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, VLD_LEN + 1))
		else $error("result beat without matching triangle");

	// sunlit is only reported for visible triangles
	a_sunlit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		done && sunlit |-> visible)
		else $error("sunlit set on invisible triangle");

	// an invisible triangle carries no direction and no flux
	a_invisible_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !visible |-> (dir_x == 0) && (dir_y == 0) && (dir_z == 0) &&
			(flux_longwave == 0) && (flux_shortwave == 0))
		else $error("invisible triangle with nonzero result");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one triangle beat as it enters the block
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [23:0]        area;
		logic [15:0]        lw;
		logic [15:0]        sw;
		logic               last;
	} tri_t;

	// one result beat as it leaves the block
	typedef struct packed {
		logic               vis;
		logic               lit;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic signed [31:0] flw;
		logic signed [31:0] fsw;
		logic               eot;
	} res_t;

	// one full register setting: satellite, Sun point, Earth radius
	typedef struct {
		logic [31:0] sat [3];
		logic [31:0] sun [3];
		logic [31:0] rad;
	} setting_t;

	// row of the directed table; typed rows carry a hand-written result
	typedef struct {
		int   cfg_sel;
		tri_t beat;
		bit   typed;
		res_t res;
	} row_t;

	localparam int LIMIT = 600000;
	localparam int LATENCY = 96;
	localparam int TRI_W = $bits(tri_t);

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	tri_t drv;
	logic cfg_we;
	etrf_pkg::reg_idx_t cfg_index;
	logic [31:0] cfg_data;
	logic done;
	res_t mon;

	earth_triangle_radiation_flux uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.centroid_x(drv.cx),
		.centroid_y(drv.cy),
		.centroid_z(drv.cz),
		.tri_area(drv.area),
		.longwave_radiance(drv.lw),
		.shortwave_radiance(drv.sw),
		.last_triangle(drv.last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.visible(mon.vis),
		.sunlit(mon.lit),
		.dir_x(mon.dx),
		.dir_y(mon.dy),
		.dir_z(mon.dz),
		.flux_longwave(mon.flw),
		.flux_shortwave(mon.fsw),
		.end_of_table(mon.eot)
	);

	// mirror of the block's registers, kept in step with every write
	logic [31:0] sat_m [3];
	logic [31:0] sun_m [3];
	logic [31:0] rad_m;

	res_t flux_expected [$];
	int errors = 0;
	int cycles = 0;
	int beats_in = 0;
	int beats_out = 0;
	int n_vis = 0;
	int n_lit = 0;
	int n_sat = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// ---------------------------------------------------------------
	// Predictor: exact integer arithmetic, on wider operands than the block uses
	// ---------------------------------------------------------------
	function automatic logic [127:0] isqrt(input logic [255:0] x);
		logic [127:0] r;
		logic [127:0] t;
		logic [255:0] sq;
		r = '0;
		for (int b = 127; b >= 0; b--) begin
			t = r | (128'd1 << b);
			sq = {128'd0, t} * {128'd0, t};
			if (sq <= x) r = t;
		end
		return r;
	endfunction

	// p . c, exact and signed
	function automatic logic signed [127:0] dot3(input logic [31:0] p [3],
			input tri_t t);
		logic signed [127:0] acc;
		logic signed [127:0] pe;
		logic signed [127:0] ce [3];
		ce[0] = t.cx;
		ce[1] = t.cy;
		ce[2] = t.cz;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			pe = $signed(p[i]);
			acc = acc + pe * ce[i];
		end
		return acc;
	endfunction

	function automatic logic [31:0] flux_scale(input logic [15:0] rad,
			input logic [23:0] area, input logic [255:0] nmag, input bit nneg,
			input logic [255:0] den);
		logic [255:0] num;
		logic [255:0] q;
		logic [31:0] m;
		num = (({240'd0, rad} * {232'd0, area}) * nmag) << 71;
		if (num == '0) return '0;
		if (den == '0) begin
			m = etrf_pkg::FLUX_MAX;
		end else begin
			q = num / den;
			m = (q > {224'd0, etrf_pkg::FLUX_MAX}) ? etrf_pkg::FLUX_MAX : q[31:0];
		end
		return nneg ? -m : m;
	endfunction

	function automatic res_t flux_predict(input tri_t t);
		res_t r;
		logic signed [127:0] r2;
		logic signed [127:0] dvec [3];
		logic signed [127:0] ce [3];
		logic signed [127:0] se;
		logic [255:0] d2;
		logic [255:0] s2;
		logic [255:0] sqd;
		logic [255:0] r2w;
		logic [255:0] qsum;
		logic [255:0] nmag;
		logic [255:0] den;
		logic [127:0] m;
		logic [31:0] dm [3];
		bit nneg;
		bit lit;
		r = '0;
		r.eot = t.last;
		r2 = {64'd0, 64'(rad_m) * 64'(rad_m)};
		if (!(dot3(sat_m, t) > r2)) return r;
		lit = dot3(sun_m, t) > r2;
		r.vis = 1'b1;
		r.lit = lit;
		ce[0] = t.cx;
		ce[1] = t.cy;
		ce[2] = t.cz;
		d2 = '0;
		s2 = '0;
		for (int i = 0; i < 3; i++) begin
			se = $signed(sat_m[i]);
			dvec[i] = se - ce[i];
			d2 = d2 + 256'(dvec[i] * dvec[i]);
			s2 = s2 + 256'(se * se);
		end
		for (int i = 0; i < 3; i++) dm[i] = '0;
		if (d2 != '0) begin
			for (int i = 0; i < 3; i++) begin
				sqd = 256'(dvec[i] * dvec[i]);
				m = isqrt((sqd << 60) / d2);
				dm[i] = (dvec[i] < 0) ? -m[31:0] : m[31:0];
			end
		end
		r.dx = dm[0];
		r.dy = dm[1];
		r.dz = dm[2];
		r2w = {128'd0, r2};
		qsum = d2 + r2w;
		nneg = s2 < qsum;
		nmag = nneg ? qsum - s2 : s2 - qsum;
		den = {224'd0, etrf_pkg::PI30} * {224'd0, rad_m} * d2 * {128'd0, isqrt(d2)};
		r.flw = flux_scale(t.lw, t.area, nmag, nneg, den);
		if (lit) r.fsw = flux_scale(t.sw, t.area, nmag, nneg, den);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("[%0t] mismatch on result %0d, %s: got %h, expected %h",
			$realtime, beats_out, what, got, want);
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	// take each result beat at the edge that ends its cycle
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (flux_expected.size() == 0) begin
				report_mismatch("unexpected beat", 32'(mon.vis), 32'd0);
			end else begin
				want = flux_expected.pop_front();
				compare_field("visible", 32'(mon.vis), 32'(want.vis));
				compare_field("sunlit", 32'(mon.lit), 32'(want.lit));
				compare_field("dir_x", mon.dx, want.dx);
				compare_field("dir_y", mon.dy, want.dy);
				compare_field("dir_z", mon.dz, want.dz);
				compare_field("flux_longwave", mon.flw, want.flw);
				compare_field("flux_shortwave", mon.fsw, want.fsw);
				compare_field("end_of_table", 32'(mon.eot), 32'(want.eot));
				if (want.vis) n_vis++;
				if (want.lit) n_lit++;
				if (want.flw == $signed(etrf_pkg::FLUX_MAX) ||
						want.flw == -$signed(etrf_pkg::FLUX_MAX))
					n_sat++;
			end
			beats_out++;
		end
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, flux_expected.size());
			$display("earth_triangle_radiation_flux test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------
	// hold until every expected beat is back, then let the pipe flush
	task automatic drain();
		while (flux_expected.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic write_reg(input etrf_pkg::reg_idx_t idx, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			etrf_pkg::REG_SAT_X: sat_m[0] = val;
			etrf_pkg::REG_SAT_Y: sat_m[1] = val;
			etrf_pkg::REG_SAT_Z: sat_m[2] = val;
			etrf_pkg::REG_SUN_X: sun_m[0] = val;
			etrf_pkg::REG_SUN_Y: sun_m[1] = val;
			etrf_pkg::REG_SUN_Z: sun_m[2] = val;
			etrf_pkg::REG_EARTH_R: rad_m = val;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input setting_t s);
		drain();
		write_reg(etrf_pkg::REG_SAT_X, s.sat[0]);
		write_reg(etrf_pkg::REG_SAT_Y, s.sat[1]);
		write_reg(etrf_pkg::REG_SAT_Z, s.sat[2]);
		write_reg(etrf_pkg::REG_SUN_X, s.sun[0]);
		write_reg(etrf_pkg::REG_SUN_Y, s.sun[1]);
		write_reg(etrf_pkg::REG_SUN_Z, s.sun[2]);
		write_reg(etrf_pkg::REG_EARTH_R, s.rad);
	endtask

	// present one beat; called at a falling edge, returns at a falling edge
	task automatic send_beat(input tri_t t, input int idle_pct, input bit typed,
			input res_t typed_res);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		drv = t;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		flux_expected.insert(flux_expected.size(),
			typed ? typed_res : flux_predict(t));
		beats_in++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd_coord(input real u, input real scale);
		return 32'($rtoi(u * scale));
	endfunction

	function automatic real rnd_unit();
		return (real'($urandom_range(2000000)) - 1000000.0) / 1000000.0;
	endfunction

	// centroid on the sphere of radius rad_m (or a stand-in if that is degenerate);
	// half of them cluster round the sub-satellite point so most are seen
	function automatic tri_t sphere_tri();
		tri_t t;
		real u [3];
		real sv [3];
		real n;
		real sn;
		real rr;
		rr = (rad_m == 0 || rad_m > 32'h4000_0000) ? 26124849.0 : real'(rad_m);
		for (int i = 0; i < 3; i++) begin
			u[i] = rnd_unit();
			sv[i] = real'($signed(sat_m[i]));
		end
		sn = $sqrt(sv[0] * sv[0] + sv[1] * sv[1] + sv[2] * sv[2]);
		if ($urandom_range(1) == 1 && sn > 0.0) begin
			for (int i = 0; i < 3; i++) u[i] = sv[i] / sn + 0.3 * u[i];
		end
		n = $sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
		if (n == 0.0) n = 1.0;
		t.cx = rnd_coord(u[0] / n, rr);
		t.cy = rnd_coord(u[1] / n, rr);
		t.cz = rnd_coord(u[2] / n, rr);
		case ($urandom_range(3))
			0: t.area = 24'($urandom);
			1: t.area = 24'($urandom_range(5000));
			default: t.area = 24'($urandom_range(300000));
		endcase
		t.lw = 16'($urandom);
		t.sw = 16'($urandom);
		t.last = ($urandom_range(15) == 0);
		return t;
	endfunction

	function automatic tri_t noise_tri();
		tri_t t;
		t = TRI_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		return t;
	endfunction

	function automatic setting_t make_setting(input int sel);
		setting_t s;
		real u [3];
		real n;
		s.rad = etrf_pkg::EARTH_R_RESET;
		for (int i = 0; i < 3; i++) begin
			s.sat[i] = '0;
			s.sun[i] = '0;
		end
		case (sel)
			0: ;	// reset values: satellite at the origin sees nothing
			1: begin
				s.sat[0] = 32'sd28672000;
				s.sun[0] = 32'sd2147483647;
			end
			2: begin
				s.sat = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
				s.sun = '{32'h0, 32'h7fff_ffff, 32'h0};
			end
			3: begin
				// zero radius: every divisor built on R is zero
				s.sat = '{32'sd30000000, 32'sd1000000, -32'sd2000000};
				s.sun = '{32'sd1, 32'sd0, 32'sd0};
				s.rad = 32'h0;
			end
			4: begin
				s.sat = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
				s.sun = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
				s.rad = 32'hffff_ffff;
			end
			default: begin
				for (int i = 0; i < 3; i++) u[i] = rnd_unit();
				n = $sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
				if (n == 0.0) n = 1.0;
				s.rad = 32'(26000000 + $urandom_range(400000));
				for (int i = 0; i < 3; i++) begin
					s.sat[i] = rnd_coord(u[i] / n, real'(s.rad) * 1.12);
					s.sun[i] = rnd_coord(rnd_unit(), 2.0e9);
				end
			end
		endcase
		return s;
	endfunction

	// ---------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------
	localparam int N_ROWS = 16;
	row_t rows [N_ROWS];

	task automatic build_table();
		res_t z;
		z = '0;
		// reset setting: the satellite sits at the origin, so nothing is
		// visible and only the end marker comes through
		rows[0] = '{0, '{32'sd0, 32'sd0, 32'sd0, 24'd0, 16'd0, 16'd0, 1'b0}, 1, z};
		rows[1] = '{0, '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 24'hffffff,
			16'hffff, 16'hffff, 1'b1}, 1, '{1'b0, 1'b0, 32'd0, 32'd0, 32'd0,
			32'd0, 32'd0, 1'b1}};
		rows[2] = '{0, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'd1,
			16'd1, 16'd1, 1'b0}, 1, z};
		// satellite on +X, Sun far along +X
		rows[3] = '{1, '{32'sd26124849, 32'sd0, 32'sd0, 24'd1000, 16'd20000,
			16'd15000, 1'b0}, 0, z};
		// far side of the Earth: hidden, typed
		rows[4] = '{1, '{-32'sd26124849, 32'sd0, 32'sd0, 24'hffffff, 16'hffff,
			16'hffff, 1'b1}, 1, '{1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
			1'b1}};
		// centroid on the satellite: zero distance
		rows[5] = '{1, '{32'sd28672000, 32'sd0, 32'sd0, 24'd500, 16'd640,
			16'd640, 1'b0}, 0, z};
		rows[6] = '{1, '{32'sd26000000, 32'sd2000000, -32'sd1500000, 24'hffffff,
			16'hffff, 16'hffff, 1'b0}, 0, z};
		// limb: seen, and lit by the Sun as well
		rows[7] = '{1, '{32'sd25000000, 32'sd7500000, 32'sd0, 24'd0, 16'd100,
			16'd100, 1'b0}, 0, z};
		rows[8] = '{1, '{32'sd26124849, 32'sd0, 32'sd0, 24'd1, 16'd0, 16'hffff,
			1'b1}, 0, z};
		// extreme satellite: large values, flux saturation likely
		rows[9] = '{2, '{32'sd0, 32'sd26124849, 32'sd0, 24'hffffff, 16'hffff,
			16'hffff, 1'b0}, 0, z};
		rows[10] = '{2, '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 24'd7,
			16'd3, 16'd9, 1'b0}, 0, z};
		rows[11] = '{2, '{-32'sd18000000, 32'sd18000000, 32'sd0, 24'd1000,
			16'd1000, 16'd1000, 1'b1}, 0, z};
		// zero radius: zero divisor
		rows[12] = '{3, '{32'sd1000, 32'sd0, 32'sd0, 24'd1000, 16'd1000,
			16'd1000, 1'b0}, 0, z};
		rows[13] = '{3, '{32'sd30000000, 32'sd1000000, -32'sd2000000, 24'd99,
			16'hffff, 16'hffff, 1'b0}, 0, z};
		// maximal radius: nothing clears R squared
		rows[14] = '{4, '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 24'hffffff,
			16'hffff, 16'hffff, 1'b1}, 0, z};
		rows[15] = '{4, '{32'sd5, -32'sd5, 32'sd0, 24'd0, 16'd0, 16'd0, 1'b0},
			0, z};
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		int cur_sel;
		int idle_pct;
		int n_rand;
		int phase_len;
		tri_t t;
		arst_n = 1'b0;
		start = 1'b0;
		drv = '0;
		cfg_we = 1'b0;
		cfg_index = etrf_pkg::REG_SAT_X;
		cfg_data = '0;
		for (int i = 0; i < 3; i++) begin
			sat_m[i] = '0;
			sun_m[i] = '0;
		end
		rad_m = etrf_pkg::EARTH_R_RESET;
		build_table();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// walk the directed table; a new setting waits for an empty pipe
		cur_sel = 0;
		foreach (rows[i]) begin
			if (rows[i].cfg_sel != cur_sel) begin
				start = 1'b0;
				cur_sel = rows[i].cfg_sel;
				apply_setting(make_setting(cur_sel));
			end
			send_beat(rows[i].beat, 0, rows[i].typed, rows[i].res);
		end

		// random part: sender idles 10%, then 58%, then none, idle-free stretches aside;
		// settings cycle through fixed extremes and random geometry
		n_rand = 1650;
		phase_len = 110;
		for (int k = 0; k < n_rand; k++) begin
			if (k % phase_len == 0) begin
				start = 1'b0;
				// pause for the full drain, then switch geometry
				cur_sel = (k / phase_len) % 3 == 2 ? 1 + $urandom_range(3)
					: 5;
				apply_setting(make_setting(cur_sel));
			end
			idle_pct = (k < n_rand / 3) ? 10 : (k < 2 * n_rand / 3) ? 58 : 0;
			if (k % 200 > 170) idle_pct = 0;
			t = ($urandom_range(3) == 0) ? noise_tri() : sphere_tri();
			send_beat(t, idle_pct, 0, '0);
		end
		start = 1'b0;

		drain();
		$display("%0d triangles sent, %0d results checked: %0d seen, %0d sunlit,",
			beats_in, beats_out, n_vis, n_lit);
		$display("%0d saturated longwave fluxes, %0d mismatches", n_sat, errors);
		if (errors == 0 && flux_expected.size() == 0) begin
			$display("earth_triangle_radiation_flux test passed");
		end else begin
			$display("earth_triangle_radiation_flux test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/etrf_pkg.sv
hw/rtl/etrf_dly.sv
hw/rtl/etrf_mul.sv
hw/rtl/etrf_div.sv
hw/rtl/etrf_sqrt.sv
hw/rtl/earth_triangle_radiation_flux.sv
test/tb.sv
